>>> hdl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared widths, constants and types for the step record statistics block.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int STEP_W       = 17;
  localparam int CNT_OUT_W    = 11;
  localparam int IDX_OUT_W    = 10;
  localparam int MEAN_W       = 17;
  localparam int MAX_RECORDS  = 1024;
  localparam int DIV_STEPS    = MEAN_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [STEP_W-1:0] THRESH_RESET = STEP_W'(500);

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    step_t step_count;
    logic  last_record;
  } srs_in_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] record_count;
    logic [IDX_OUT_W-1:0] min_index;
    logic [IDX_OUT_W-1:0] max_index;
    logic [MEAN_W-1:0]    mean_steps;
    logic [IDX_OUT_W-1:0] run_start;
    logic [IDX_OUT_W-1:0] run_end;
    logic                 run_found;
    logic                 empty_set;
    logic                 overflow_flag;
  } srs_out_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_DIVIDE,
    ST_REPORT
  } srs_state_e;

  typedef struct packed {
    logic take;      // apply the accepted sample
    logic snap;      // last record: capture report, clear set, load divider
    logic div_step;  // one quotient bit
    logic load_out;  // move report into output register
  } srs_cmd_t;

endpackage

>>> hdl/srs_stream_if.sv
// ----------------------------------------------------------------------------
// srs_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface srs_stream_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

>>> hdl/step_record_statistics.sv
// ----------------------------------------------------------------------------
// step_record_statistics
// Running statistics over a set of step-count records with a report per set.
// ----------------------------------------------------------------------------
// Samples are taken one per clock while collecting. A sample marked last is
// folded in, then the set is cleared and the mean is computed by a radix-2
// restoring divider at one quotient bit per cycle; the report is then loaded
// into the output register, and only after that is the next sample taken
// (later if the previous report has not been transferred).
// The report waits in an output register while collection goes on. Samples
// past MaxRecords in a set are dropped and flagged. The threshold write
// port is always ready.
module step_record_statistics #(
  parameter int MaxRecords = srs_pkg::MAX_RECORDS
) (
  input logic          clk_i,
  input logic          rst_ni,
  srs_stream_if.sink   cfg_i,
  srs_stream_if.sink   samp_i,
  srs_stream_if.source rpt_o
);
  import srs_pkg::*;

  srs_cmd_t cmd;
  srs_in_t  sample;
  srs_out_t rpt;
  step_t    cfg_data;

  assign sample      = samp_i.payload;
  assign cfg_data    = cfg_i.payload;
  assign cfg_i.ready = 1'b1;
  assign rpt_o.payload = rpt;

  srs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (samp_i.valid),
    .in_last_i   (sample.last_record),
    .in_ready_o  (samp_i.ready),
    .out_ready_i (rpt_o.ready),
    .out_valid_o (rpt_o.valid),
    .cmd_o       (cmd)
  );

  srs_datapath #(
    .MaxRecords (MaxRecords)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .step_i     (sample.step_count),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_data),
    .rpt_o      (rpt)
  );

endmodule

>>> hdl/srs_ctrl.sv
// ----------------------------------------------------------------------------
// srs_ctrl
// Sequencer: collect samples, run the mean divider, hand off the report.
// ----------------------------------------------------------------------------
module srs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output srs_pkg::srs_cmd_t cmd_o
);
  import srs_pkg::*;

  srs_state_e           state_q, state_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_COLLECT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_last_i) begin
            cmd_o.snap = 1'b1;
            step_d     = '0;
            state_d    = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + DIV_CNT_W'(1);
        if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/srs_datapath.sv
// ----------------------------------------------------------------------------
// srs_datapath
// Running min/max/sum/run trackers, report capture, restoring mean divider
// and output register.
// ----------------------------------------------------------------------------
module srs_datapath #(
  parameter int MaxRecords = srs_pkg::MAX_RECORDS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srs_pkg::srs_cmd_t cmd_i,
  input  srs_pkg::step_t    step_i,
  input  logic              cfg_we_i,
  input  srs_pkg::step_t    cfg_data_i,
  output srs_pkg::srs_out_t rpt_o
);
  import srs_pkg::*;

  localparam int CntW = $clog2(MaxRecords + 1);
  localparam int IdxW = $clog2(MaxRecords);
  localparam int SumW = STEP_W + CntW;
  localparam int DvdW = SumW + 1;
  localparam int DvsW = CntW + 1;
  localparam int RemW = CntW + 2;

  step_t            thresh_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  step_t            low_q, low_d;
  logic [IdxW-1:0]  low_pos_q, low_pos_d;
  step_t            high_q, high_d;
  logic [IdxW-1:0]  high_pos_q, high_pos_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]  act_q, act_d;
  logic [CntW-1:0]  best_q, best_d;
  logic [IdxW-1:0]  bend_q, bend_d;
  logic             drop_q, drop_d;

  logic [CntW-1:0]  rep_cnt_q;
  logic [IdxW-1:0]  rep_min_q, rep_max_q, rep_start_q, rep_end_q;
  logic             rep_found_q, rep_empty_q, rep_drop_q;

  logic [RemW-1:0]  rem_q;
  logic [MEAN_W-1:0] quo_q;
  logic [DvsW-1:0]  dvs_q;

  srs_out_t         out_q;

  step_t            s;
  logic             full;
  logic [IdxW-1:0]  idx;
  logic [CntW-1:0]  start_w;
  logic [DvdW-1:0]  dividend;
  logic [RemW-1:0]  trial;
  logic             fits;

  assign s    = step_i;
  assign full = (cnt_q == CntW'(MaxRecords));
  assign idx  = cnt_q[IdxW-1:0];

  always_comb begin
    cnt_d      = cnt_q;
    low_d      = low_q;
    low_pos_d  = low_pos_q;
    high_d     = high_q;
    high_pos_d = high_pos_q;
    sum_d      = sum_q;
    act_d      = act_q;
    best_d     = best_q;
    bend_d     = bend_q;
    drop_d     = drop_q;
    if (full) begin
      drop_d = 1'b1;
    end else begin
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == '0 || s < low_q) begin
        low_d     = s;
        low_pos_d = idx;
      end
      if (s > high_q) begin
        high_d     = s;
        high_pos_d = idx;
      end
      sum_d = sum_q + SumW'(s);
      act_d = (s > thresh_q) ? act_q + CntW'(1) : '0;
      if (act_d != '0 && act_d >= best_q) begin
        best_d = act_d;
        bend_d = idx;
      end
    end
  end

  assign start_w  = CntW'(bend_d) + CntW'(1) - best_d;
  assign dividend = {sum_d, 1'b0} + DvdW'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      low_q      <= '0;
      low_pos_q  <= '0;
      high_q     <= '0;
      high_pos_q <= '0;
      sum_q      <= '0;
      act_q      <= '0;
      best_q     <= '0;
      bend_q     <= '0;
      drop_q     <= 1'b0;
    end else if (cmd_i.snap) begin
      cnt_q      <= '0;
      low_q      <= '0;
      low_pos_q  <= '0;
      high_q     <= '0;
      high_pos_q <= '0;
      sum_q      <= '0;
      act_q      <= '0;
      best_q     <= '0;
      bend_q     <= '0;
      drop_q     <= 1'b0;
    end else if (cmd_i.take) begin
      cnt_q      <= cnt_d;
      low_q      <= low_d;
      low_pos_q  <= low_pos_d;
      high_q     <= high_d;
      high_pos_q <= high_pos_d;
      sum_q      <= sum_d;
      act_q      <= act_d;
      best_q     <= best_d;
      bend_q     <= bend_d;
      drop_q     <= drop_d;
    end
  end

  // Report capture (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      rep_cnt_q   <= cnt_d;
      rep_empty_q <= (cnt_d == '0);
      rep_min_q   <= (cnt_d == '0) ? '0 : low_pos_d;
      rep_max_q   <= (cnt_d == '0) ? '0 : high_pos_d;
      rep_found_q <= (best_d != '0);
      rep_end_q   <= (best_d != '0) ? bend_d : '0;
      rep_start_q <= (best_d != '0) ? start_w[IdxW-1:0] : '0;
      rep_drop_q  <= drop_d;
    end
  end

  // Radix-2 restoring divider: quotient < 2**MEAN_W, so the upper dividend
  // bits start out below the divisor.
  assign trial = {rem_q[RemW-2:0], quo_q[MEAN_W-1]};
  assign fits  = (trial >= RemW'(dvs_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      rem_q <= RemW'(dividend[DvdW-1:MEAN_W]);
      quo_q <= dividend[MEAN_W-1:0];
      dvs_q <= {cnt_d, 1'b0};
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? trial - RemW'(dvs_q) : trial;
      quo_q <= {quo_q[MEAN_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.record_count  <= CNT_OUT_W'(rep_cnt_q);
      out_q.min_index     <= IDX_OUT_W'(rep_min_q);
      out_q.max_index     <= IDX_OUT_W'(rep_max_q);
      out_q.mean_steps    <= rep_empty_q ? '0 : quo_q;
      out_q.run_start     <= IDX_OUT_W'(rep_start_q);
      out_q.run_end       <= IDX_OUT_W'(rep_end_q);
      out_q.run_found     <= rep_found_q;
      out_q.empty_set     <= rep_empty_q;
      out_q.overflow_flag <= rep_drop_q;
    end
  end

  assign rpt_o = out_q;

endmodule
